// ===== design/owring_pkg.sv =====
// Shared constants, request codes, state type and pointer helper for the sample ring.
`default_nettype none
package owring_pkg;

  localparam int RING_DEPTH = 65536;
  localparam int MAX_BURST  = 64;

  localparam int SAMPLE_W  = 16;
  localparam int REQ_W     = 2;
  localparam int COUNT_W   = 7;
  localparam int FILL_W    = 16;
  localparam int PTR_W     = $clog2(RING_DEPTH);
  localparam int BURST_W   = $clog2(MAX_BURST + 1);

  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_t;

  typedef logic [PTR_W-1:0] ptr_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ===== design/owring_ram.sv =====
// Simple dual-port sample memory, one write and one registered read port.
`default_nettype none
module owring_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/overwrite_oldest_sample_ring_core.sv =====
// Top level: drop-oldest sample ring with pointer control and burst read sequencer.
//
//  channel  | handshake        | fields
//  ---------+------------------+-------------------------------------------------
//  request  | start / busy     | req_type, sample_in, read_count
//  result   | strobe (1 cycle) | sample_out, sample_valid, last_of_run,
//           |                  | dropped_oldest, fill_count
//
// Push and clear: the result word shows the cycle after accept and busy stays
// low, so one push per cycle is sustained.
// A read burst does one memory read per word; busy is high while the burst's
// later reads are issued, and each word shows the cycle after its read.
// An empty or zero-length read gives one word. Results cannot be stalled.
// Synchronous reset empties the ring; the memory has no reset or clearing pass.
`default_nettype none
module overwrite_oldest_sample_ring_core
  import owring_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic [REQ_W-1:0]           req_type,
  input  wire logic signed [SAMPLE_W-1:0] sample_in,
  input  wire logic [COUNT_W-1:0]         read_count,
  output      logic                       strobe,
  output      logic signed [SAMPLE_W-1:0] sample_out,
  output      logic                       sample_valid,
  output      logic                       last_of_run,
  output      logic                       dropped_oldest,
  output      logic [FILL_W-1:0]          fill_count
);

  state_t state, state_next;

  ptr_t wp, wp_next;
  ptr_t rp, rp_next;
  ptr_t fill, fill_next;
  logic [BURST_W-1:0] remaining, remaining_next;

  logic        res_strobe, res_strobe_next;
  logic        res_from_ram, res_from_ram_next;
  logic        res_last, res_last_next;
  logic        res_drop, res_drop_next;
  ptr_t        res_fill, res_fill_next;

  logic                accept;
  logic                push_go, read_go, clear_go;
  logic                full;
  logic                issue;
  logic [COUNT_W-1:0]  want_sat;
  logic [31:0]         want_ext, fill_ext, res_fill_ext;
  logic [BURST_W-1:0]  burst_n;
  logic [SAMPLE_W-1:0] ram_q;

  assign accept   = start && !busy;
  assign push_go  = accept && (req_type == REQ_PUSH);
  assign read_go  = accept && (req_type == REQ_READ);
  assign clear_go = accept && (req_type == REQ_CLEAR);
  assign full     = (fill == PTR_W'(RING_DEPTH - 1));

  // burst length = min(request, MAX_BURST, fill)
  assign want_sat = (read_count > COUNT_W'(MAX_BURST)) ? COUNT_W'(MAX_BURST) : read_count;
  assign want_ext = 32'(want_sat);
  assign fill_ext = 32'(fill);
  assign burst_n  = (want_ext < fill_ext) ? BURST_W'(want_ext) : BURST_W'(fill_ext);

  assign issue = (read_go && (burst_n != '0)) || (state == ST_BURST);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (read_go && (burst_n > BURST_W'(1))) begin
          state_next = ST_BURST;
        end
      end
      ST_BURST: begin
        if (remaining == BURST_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: pointers, fill and result word
  always_comb begin
    wp_next           = wp;
    rp_next           = rp;
    fill_next         = fill;
    remaining_next    = remaining;
    res_strobe_next   = 1'b0;
    res_from_ram_next = 1'b0;
    res_last_next     = 1'b1;
    res_drop_next     = 1'b0;
    res_fill_next     = fill;

    if (issue) begin
      rp_next           = ring_next(rp);
      fill_next         = fill - 1'b1;
      res_strobe_next   = 1'b1;
      res_from_ram_next = 1'b1;
      res_fill_next     = fill - 1'b1;
      if (state == ST_BURST) begin
        remaining_next = remaining - 1'b1;
        res_last_next  = (remaining == BURST_W'(1));
      end else begin
        remaining_next = burst_n - 1'b1;
        res_last_next  = (burst_n == BURST_W'(1));
      end
    end else if (read_go) begin
      // nothing to return
      res_strobe_next = 1'b1;
    end else if (push_go) begin
      wp_next         = ring_next(wp);
      res_strobe_next = 1'b1;
      if (full) begin
        rp_next       = ring_next(rp);
        res_drop_next = 1'b1;
      end else begin
        fill_next     = fill + 1'b1;
        res_fill_next = fill + 1'b1;
      end
    end else if (clear_go) begin
      wp_next         = '0;
      rp_next         = '0;
      fill_next       = '0;
      res_strobe_next = 1'b1;
      res_fill_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wp         <= '0;
      rp         <= '0;
      fill       <= '0;
      remaining  <= '0;
      res_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      wp         <= wp_next;
      rp         <= rp_next;
      fill       <= fill_next;
      remaining  <= remaining_next;
      res_strobe <= res_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    res_from_ram <= res_from_ram_next;
    res_last     <= res_last_next;
    res_drop     <= res_drop_next;
    res_fill     <= res_fill_next;
  end

  owring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_ram (
    .clk   (clk),
    .we    (push_go),
    .waddr (wp),
    .wdata (sample_in),
    .re    (issue),
    .raddr (rp),
    .rdata (ram_q)
  );

  assign res_fill_ext = 32'(res_fill);

  assign busy           = (state == ST_BURST);
  assign strobe         = res_strobe;
  assign sample_out     = res_from_ram ? ram_q : '0;
  assign sample_valid   = res_from_ram;
  assign last_of_run    = res_last;
  assign dropped_oldest = res_drop;
  assign fill_count     = res_fill_ext[FILL_W-1:0];

endmodule
`default_nettype wire
